// ----- rtl/moving_average_crossover_signal_core_assert.svh -----
// Assertion macros for the crossover core checker.
`ifndef MOVING_AVERAGE_CROSSOVER_SIGNAL_CORE_ASSERT_SVH
`define MOVING_AVERAGE_CROSSOVER_SIGNAL_CORE_ASSERT_SVH

// Checked only out of reset.
`define MACS_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checked on the next edge, only out of reset.
`define MACS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Checked at every edge, reset included.
`define MACS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/macs_pkg.sv -----
package macs_pkg;

  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_W-1:0] SHORT_WINDOW_RST = 9'd5;
  localparam logic [CFG_W-1:0] LONG_WINDOW_RST  = 9'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_WINDOW = 1'b0,
    REG_LONG_WINDOW  = 1'b1
  } macs_reg_e;

  typedef logic signed [1:0] macs_sign_t;

  localparam macs_sign_t SIG_ZERO = 2'sb00;
  localparam macs_sign_t SIG_POS  = 2'sb01;
  localparam macs_sign_t SIG_NEG  = 2'sb11;

endpackage

// ----- rtl/moving_average_crossover_signal_core.sv -----
// Moving-average crossover core.
// Slave stream: one price sample per beat, tdata = price (unsigned 16.16),
// tlast marks the last sample of a series. Master stream: one result per
// input beat, tdata = signal (2-bit signed: +1 buy, -1 sell, 0 none), tuser
// = signal valid (long window full).
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 short window, 1 long window); any write clears the stream state.
// Write only while no beat is in flight.
// Beats pass stages 1 to 3 and the output register. Throughput: one beat per
// cycle unless a held result stalls the pipe, set by the running-sum update.
// The samples sit in a row of shift cells, one short and one long lane per
// cell; each window's sample enters at its start cell and leaves the last
// cell as its oldest member. Behind that, a split multiply and a compare run
// in a 4-deep pipeline.
// Reset: windows return to 5 and 20, sums, counts and signal history clear,
// the pipeline empties. No clearing pass is needed.
// Stall: a held result keeps its beat; the pipeline holds up to four beats,
// the held one included, before s_axis_tready drops.
module moving_average_crossover_signal_core #(
  parameter int MAX_WINDOW = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [((PRICE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // [PRICE_BITS-1:0] price
  input  logic                             s_axis_tlast,  // final sample
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [macs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [1:0] signal
  output logic                             m_axis_tuser,  // [0] signal valid
  input  logic                             cfg_we_i,
  input  logic [macs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [macs_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int NW     = $clog2(MAX_WINDOW + 1);
  localparam int IW     = $clog2(MAX_WINDOW);
  localparam int SUM_W  = PRICE_BITS + IW;
  localparam int LO_W   = (SUM_W + 1) / 2;
  localparam int HI_W   = SUM_W - LO_W;
  localparam int PROD_W = SUM_W + NW;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } flags_t;

  function automatic logic [NW-1:0] clamp_len(input logic [macs_pkg::CFG_W-1:0] v);
    logic [NW-1:0] r;
    if (v == '0) begin
      r = NW'(1);
    end else if (32'(v) > 32'(MAX_WINDOW)) begin
      r = NW'(MAX_WINDOW);
    end else begin
      r = NW'(v);
    end
    return r;
  endfunction

  // configuration
  logic [macs_pkg::CFG_W-1:0] short_win_q, long_win_q;
  logic [NW-1:0]              len_a, len_b, ns, nl;
  logic [IW-1:0]              start_s, start_l;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_win_q <= macs_pkg::SHORT_WINDOW_RST;
      long_win_q  <= macs_pkg::LONG_WINDOW_RST;
    end else if (cfg_we_i) begin
      case (macs_pkg::macs_reg_e'(cfg_idx_i))
        macs_pkg::REG_SHORT_WINDOW: short_win_q <= cfg_data_i;
        macs_pkg::REG_LONG_WINDOW:  long_win_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign len_a   = clamp_len(short_win_q);
  assign len_b   = clamp_len(long_win_q);
  assign ns      = (len_a < len_b) ? len_a : len_b;
  assign nl      = (len_a < len_b) ? len_b : len_a;
  assign start_s = IW'(32'(MAX_WINDOW) - 32'(ns));
  assign start_l = IW'(32'(MAX_WINDOW) - 32'(nl));

  // handshake
  logic v1_q, v2_q, v3_q, m_valid_q;
  logic rdy1, rdy2, rdy3, rdy_out, in_fire;

  assign rdy_out       = !m_valid_q || m_axis_tready;
  assign rdy3          = !v3_q || rdy_out;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign in_fire       = s_axis_tvalid && rdy1;

  // sample cells
  logic [PRICE_BITS-1:0] price;
  logic [PRICE_BITS-1:0] chain_s [MAX_WINDOW+1];
  logic [PRICE_BITS-1:0] chain_l [MAX_WINDOW+1];

  assign price      = s_axis_tdata[PRICE_BITS-1:0];
  assign chain_s[0] = price;
  assign chain_l[0] = price;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    macs_cell #(
      .IDX (i),
      .IW  (IW),
      .W   (PRICE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .shift_i   (in_fire),
      .start_s_i (start_s),
      .start_l_i (start_l),
      .price_i   (price),
      .prev_s_i  (chain_s[i]),
      .prev_l_i  (chain_l[i]),
      .tap_s_o   (chain_s[i+1]),
      .tap_l_o   (chain_l[i+1])
    );
  end

  // running sums
  logic [SUM_W-1:0] sum_s_q, sum_l_q, sum_s_d, sum_l_d;
  logic [NW-1:0]    seen_q, seen_inc;
  logic [PRICE_BITS-1:0] drop_s, drop_l;
  flags_t           flags_in;

  assign drop_s   = (seen_q >= ns) ? chain_s[MAX_WINDOW] : '0;
  assign drop_l   = (seen_q >= nl) ? chain_l[MAX_WINDOW] : '0;
  assign sum_s_d  = sum_s_q + SUM_W'(price) - SUM_W'(drop_s);
  assign sum_l_d  = sum_l_q + SUM_W'(price) - SUM_W'(drop_l);
  assign seen_inc = seen_q + NW'(1);

  assign flags_in.valid = (seen_q >= nl) || (seen_inc == nl);
  assign flags_in.first = (seen_q < nl) && (seen_inc == nl);
  assign flags_in.last  = s_axis_tlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_s_q <= '0;
      sum_l_q <= '0;
      seen_q  <= '0;
    end else if (cfg_we_i) begin
      sum_s_q <= '0;
      sum_l_q <= '0;
      seen_q  <= '0;
    end else if (in_fire) begin
      if (s_axis_tlast) begin
        sum_s_q <= '0;
        sum_l_q <= '0;
        seen_q  <= '0;
      end else begin
        sum_s_q <= sum_s_d;
        sum_l_q <= sum_l_d;
        if (seen_q < nl) begin
          seen_q <= seen_inc;
        end
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q      <= s_axis_tvalid;
      if (rdy2)    v2_q      <= v1_q;
      if (rdy3)    v3_q      <= v2_q;
      if (rdy_out) m_valid_q <= v3_q;
    end
  end

  // stage 1: sums after this sample
  logic [SUM_W-1:0] s1_sum_s_q, s1_sum_l_q;
  flags_t           f1_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sum_s_q <= sum_s_d;
      s1_sum_l_q <= sum_l_d;
      f1_q       <= flags_in;
    end
  end

  // stage 2: cross products in halves
  logic [LO_W+NW-1:0] p_s_lo_q, p_l_lo_q;
  logic [HI_W+NW-1:0] p_s_hi_q, p_l_hi_q;
  flags_t             f2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      p_s_lo_q <= (LO_W+NW)'(s1_sum_s_q[LO_W-1:0]) * (LO_W+NW)'(nl);
      p_s_hi_q <= (HI_W+NW)'(s1_sum_s_q[SUM_W-1:LO_W]) * (HI_W+NW)'(nl);
      p_l_lo_q <= (LO_W+NW)'(s1_sum_l_q[LO_W-1:0]) * (LO_W+NW)'(ns);
      p_l_hi_q <= (HI_W+NW)'(s1_sum_l_q[SUM_W-1:LO_W]) * (HI_W+NW)'(ns);
      f2_q     <= f1_q;
    end
  end

  // stage 3: full products
  logic [PROD_W-1:0] prod_s_q, prod_l_q;
  flags_t            f3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      prod_s_q <= {p_s_hi_q, {LO_W{1'b0}}} + PROD_W'(p_s_lo_q);
      prod_l_q <= {p_l_hi_q, {LO_W{1'b0}}} + PROD_W'(p_l_lo_q);
      f3_q     <= f2_q;
    end
  end

  // crossing decision
  macs_pkg::macs_sign_t d, dd, sig, prev_q, prev_d, last_q, last_d;

  always_comb begin
    if (prod_s_q > prod_l_q) begin
      d = macs_pkg::SIG_POS;
    end else if (prod_s_q < prod_l_q) begin
      d = macs_pkg::SIG_NEG;
    end else begin
      d = macs_pkg::SIG_ZERO;
    end
    dd     = d;
    sig    = macs_pkg::SIG_ZERO;
    prev_d = prev_q;
    last_d = last_q;
    if (f3_q.valid) begin
      if (f3_q.first) begin
        prev_d = d;
      end else begin
        if (d == macs_pkg::SIG_POS && prev_q == macs_pkg::SIG_NEG) begin
          sig = macs_pkg::SIG_POS;
        end else if (d == macs_pkg::SIG_NEG && prev_q == macs_pkg::SIG_POS) begin
          sig = macs_pkg::SIG_NEG;
        end else if (d == macs_pkg::SIG_ZERO && prev_q == macs_pkg::SIG_NEG) begin
          sig = macs_pkg::SIG_POS;
          dd  = macs_pkg::SIG_POS;
        end else if (d == macs_pkg::SIG_ZERO && prev_q == macs_pkg::SIG_POS) begin
          sig = macs_pkg::SIG_NEG;
          dd  = macs_pkg::SIG_NEG;
        end
        prev_d = dd;
        if (sig != macs_pkg::SIG_ZERO) begin
          if (sig == last_q) begin
            sig = macs_pkg::SIG_ZERO;
          end else begin
            last_d = sig;
          end
        end
      end
    end
    if (f3_q.last) begin
      sig    = f3_q.valid ? -last_d : macs_pkg::SIG_ZERO;
      prev_d = macs_pkg::SIG_ZERO;
      last_d = macs_pkg::SIG_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= macs_pkg::SIG_ZERO;
      last_q <= macs_pkg::SIG_ZERO;
    end else if (cfg_we_i) begin
      prev_q <= macs_pkg::SIG_ZERO;
      last_q <= macs_pkg::SIG_ZERO;
    end else if (rdy_out && v3_q) begin
      prev_q <= prev_d;
      last_q <= last_d;
    end
  end

  // output register
  logic [1:0] m_sig_q;
  logic       m_ok_q;

  always_ff @(posedge clk_i) begin
    if (rdy_out && v3_q) begin
      m_sig_q <= sig;
      m_ok_q  <= f3_q.valid;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = macs_pkg::OUT_DATA_W'(m_sig_q);
  assign m_axis_tuser  = m_ok_q;

endmodule

// ----- rtl/macs_cell.sv -----
module macs_cell #(
  parameter int IDX = 0,
  parameter int IW  = 8,
  parameter int W   = 32
) (
  input  logic          clk_i,
  input  logic          shift_i,
  input  logic [IW-1:0] start_s_i,
  input  logic [IW-1:0] start_l_i,
  input  logic [W-1:0]  price_i,
  input  logic [W-1:0]  prev_s_i,
  input  logic [W-1:0]  prev_l_i,
  output logic [W-1:0]  tap_s_o,
  output logic [W-1:0]  tap_l_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [W-1:0] s_q, s_d;
  logic [W-1:0] l_q, l_d;

  // a window's newest sample enters at its start cell
  assign s_d = (start_s_i == MY_IDX) ? price_i : prev_s_i;
  assign l_d = (start_l_i == MY_IDX) ? price_i : prev_l_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      s_q <= s_d;
      l_q <= l_d;
    end
  end

  assign tap_s_o = s_q;
  assign tap_l_o = l_q;

endmodule

// ----- rtl/macs_chk.sv -----
`include "moving_average_crossover_signal_core_assert.svh"

module macs_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [macs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);

  `MACS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")
  `MACS_ASSERT(a_invalid_quiet, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[1:0] == macs_pkg::SIG_ZERO, "signal given before window full")
  `MACS_ASSERT(a_sig_code, m_axis_tvalid, m_axis_tdata[1:0] != 2'b10, "signal out of range")
  `MACS_ASSERT_ALWAYS(a_rst_empty, !rst_ni, !m_axis_tvalid, "result beat during reset")

endmodule

bind moving_average_crossover_signal_core macs_chk u_macs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/macs_checker.sv -----
module macs_checker
  import macs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [31:0]           s_tdata_i,
  input  logic                  s_tlast_i,
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [OUT_DATA_W-1:0] m_tdata_i,
  input  logic                  m_tuser_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  end_i,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIN = 256;

  typedef struct packed {
    macs_sign_t sig;
    logic       valid;
  } crossing_t;

  logic [31:0]      price_ring [MAX_WIN];
  logic [7:0]       wr_pos;
  logic [39:0]      short_acc;
  logic [39:0]      long_acc;
  logic [8:0]       seen;
  macs_sign_t       prev_dir;
  macs_sign_t       last_sent;
  logic [CFG_W-1:0] short_reg;
  logic [CFG_W-1:0] long_reg;
  crossing_t        expected_crossings [$];
  bit               end_seen;

  task automatic report(input string msg);
    if (fail_count_o < 40) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  function automatic int unsigned clamp_window(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIN) return MAX_WIN;
    return v;
  endfunction

  // exact sign of short mean minus long mean by cross-multiplication
  function automatic macs_sign_t sma_direction(input logic [39:0] s, input int unsigned ns,
                                               input logic [39:0] l, input int unsigned nl);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = 64'(s) * 64'(nl);
    rhs = 64'(l) * 64'(ns);
    if (lhs > rhs) return SIG_POS;
    if (lhs < rhs) return SIG_NEG;
    return SIG_ZERO;
  endfunction

  task automatic clear_series();
    wr_pos    = '0;
    short_acc = '0;
    long_acc  = '0;
    seen      = '0;
    prev_dir  = SIG_ZERO;
    last_sent = SIG_ZERO;
  endtask

  task automatic predict_crossing(input logic [31:0] price, input logic fin,
                                  output crossing_t res);
    int unsigned a;
    int unsigned b;
    int unsigned ns;
    int unsigned nl;
    macs_sign_t  dir;
    macs_sign_t  sig;
    logic        valid;
    a   = clamp_window(short_reg);
    b   = clamp_window(long_reg);
    ns  = (a < b) ? a : b;
    nl  = (a < b) ? b : a;
    sig = SIG_ZERO;
    if (seen >= ns) short_acc -= price_ring[wr_pos - 8'(ns)];
    if (seen >= nl) long_acc -= price_ring[wr_pos - 8'(nl)];
    price_ring[wr_pos] = price;
    short_acc += price;
    long_acc  += price;
    wr_pos++;
    if (seen < nl) begin
      seen++;
      valid = (seen >= nl);
      if (valid) prev_dir = sma_direction(short_acc, ns, long_acc, nl);
    end else begin
      dir   = sma_direction(short_acc, ns, long_acc, nl);
      valid = 1'b1;
      if (dir == SIG_POS && prev_dir == SIG_NEG) begin
        sig = SIG_POS;
      end else if (dir == SIG_NEG && prev_dir == SIG_POS) begin
        sig = SIG_NEG;
      end else if (dir == SIG_ZERO && prev_dir == SIG_NEG) begin
        sig = SIG_POS;
        dir = SIG_POS;
      end else if (dir == SIG_ZERO && prev_dir == SIG_POS) begin
        sig = SIG_NEG;
        dir = SIG_NEG;
      end
      prev_dir = dir;
      if (sig != SIG_ZERO) begin
        if (sig == last_sent) sig = SIG_ZERO;
        else last_sent = sig;
      end
    end
    if (fin) begin
      sig = valid ? macs_sign_t'(-last_sent) : SIG_ZERO;
      clear_series();
    end
    res.sig   = sig;
    res.valid = valid;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t want;
    crossing_t got;
    if (!rst_ni) begin
      clear_series();
      short_reg = SHORT_WINDOW_RST;
      long_reg  = LONG_WINDOW_RST;
      expected_crossings.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got.sig   = macs_sign_t'(m_tdata_i[1:0]);
        got.valid = m_tuser_i;
        if (expected_crossings.size() == 0) begin
          report($sformatf("result beat sig=%0d valid=%0b with nothing expected",
                           got.sig, got.valid));
        end else begin
          want = expected_crossings.pop_front();
          if (got.sig !== want.sig) begin
            report($sformatf("signal %0d, expected %0d", got.sig, want.sig));
          end
          if (got.valid !== want.valid) begin
            report($sformatf("signal_valid %0b, expected %0b", got.valid, want.valid));
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SHORT_WINDOW) short_reg = cfg_data_i;
        else long_reg = cfg_data_i;
        clear_series();
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_crossing(s_tdata_i, s_tlast_i, want);
        expected_crossings.insert(expected_crossings.size(), want);
      end
      if (end_i && !end_seen) begin
        end_seen = 1'b1;
        if (expected_crossings.size() != 0) begin
          report($sformatf("%0d results never arrived", expected_crossings.size()));
        end
      end
    end
    pending_o = expected_crossings.size();
  end

endmodule

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import macs_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_ITEMS = 1200;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  end_chk;
  int                    fail_count;
  int                    pending;
  int                    cycles;
  int                    burst_left;
  int                    random_items;
  int                    long_len;
  logic [31:0]           walk;

  moving_average_crossover_signal_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  macs_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tlast_i   (s_axis_tlast),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .end_i       (end_chk),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall pattern, picks a new mode after each random span
  initial begin
    int mode;
    int span;
    m_axis_tready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= ($urandom_range(0, 15) < 3);
        endcase
      end
    end
  end

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic push_sample(input logic [31:0] price, input logic fin);
    pace();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= price;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    random_items++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic int eff_len(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  task automatic set_windows(input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] l);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SHORT_WINDOW;
    cfg_data_i <= s;
    @(posedge clk_i);
    cfg_idx_i  <= REG_LONG_WINDOW;
    cfg_data_i <= l;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    long_len = (eff_len(s) > eff_len(l)) ? eff_len(s) : eff_len(l);
  endtask

  task automatic draw_price(input int style, output logic [31:0] p);
    logic [31:0] corners [4];
    corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    case (style)
      0: p = $urandom;
      1: begin
        walk = walk + 32'($urandom_range(0, 4000)) - 32'd2000;
        p = walk;
      end
      2: p = $urandom_range(0, 3);
      3: p = corners[$urandom_range(0, 3)];
      default: begin
        walk = walk + 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
        p = walk;
      end
    endcase
  endtask

  task automatic run_series(input int len, input bit close, input int style);
    logic [31:0] p;
    walk = $urandom;
    for (int i = 0; i < len; i++) begin
      draw_price(($urandom_range(0, 19) == 0) ? 0 : style, p);
      push_sample(p, close && (i == len - 1));
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    logic [31:0]      swap_seq [11];
    logic [CFG_W-1:0] sw;
    logic [CFG_W-1:0] lw;
    int               phase;
    int               len;
    int               nser;
    swap_seq = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    rst_ni        = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_SHORT_WINDOW;
    cfg_data_i    = '0;
    end_chk       = 1'b0;
    burst_left    = 0;
    random_items  = 0;
    long_len      = 20;
    walk          = '0;
    #1 rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset windows, series closed before the long window fills
    push_sample(32'h0, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b0);
    push_sample(32'h1234_5678, 1'b1);
    // swapped windows, crossings both ways, flat runs, close on a full window
    set_windows(9'd2, 9'd1);
    foreach (swap_seq[i]) push_sample(swap_seq[i], i == 10);
    // zero registers, equal windows
    set_windows(9'd0, 9'd0);
    push_sample(32'd5, 1'b0);
    push_sample(32'd9, 1'b0);
    push_sample(32'd3, 1'b1);
    set_windows(9'd1, 9'd3);
    push_sample(32'hA5A5_A5A5, 1'b0);
    push_sample(32'h5A5A_5A5A, 1'b0);
    push_sample(32'h0, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);

    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin sw = 9'd5;   lw = 9'd20;  end
        1: begin sw = 9'd1;   lw = 9'd256; end
        2: begin sw = 9'd511; lw = 9'd0;   end
        3: begin sw = 9'd3;   lw = 9'd3;   end
        4: begin sw = 9'd9;   lw = 9'd2;   end
        5: begin sw = 9'd256; lw = 9'd255; end
        default: begin
          if ($urandom_range(0, 19) == 0) begin
            sw = $urandom_range(0, 511);
            lw = $urandom_range(0, 511);
          end else begin
            sw = $urandom_range(0, 12);
            lw = $urandom_range(0, 12);
          end
        end
      endcase
      set_windows(sw, lw);
      nser = (long_len > 32) ? 1 : $urandom_range(1, 4);
      repeat (nser) begin
        if ($urandom_range(0, 99) < 15) len = $urandom_range(1, long_len);
        else len = long_len + $urandom_range(0, 60);
        run_series(len, $urandom_range(0, 9) != 0, $urandom_range(0, 4));
      end
      phase++;
    end

    drain();
    repeat (12) @(posedge clk_i);
    end_chk <= 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/macs_pkg.sv
rtl/macs_cell.sv
rtl/moving_average_crossover_signal_core.sv
rtl/macs_chk.sv
verif/macs_checker.sv
verif/tb.sv
